### sv/lpt_pkg.sv
// Package for the lowest priority task picker: transaction structs, function and
// status codes, and the entry record shared by the scan datapath.
// Depends on nothing; every other file imports it.
`default_nettype none

package lpt_pkg;

    localparam int TASK_IDX_W  = 6;
    localparam int PRIO_W      = 8;
    localparam int SLICE_W     = 32;

    localparam logic [PRIO_W-1:0] PRIO_CEILING = 8'd255;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_PEEK   = 2'd1;
    localparam logic [1:0] FUNC_SCHED  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [PRIO_W-1:0]  new_priority;
        logic [SLICE_W-1:0] new_timeslice;
    } lpt_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [TASK_IDX_W-1:0] task_index;
        logic [PRIO_W-1:0]     picked_priority;
        logic [SLICE_W-1:0]    picked_timeslice;
    } lpt_rsp_t;

    typedef struct packed {
        logic [PRIO_W-1:0]     prio;
        logic [SLICE_W-1:0]    slice;
        logic [TASK_IDX_W-1:0] idx;
    } lpt_entry_t;

    // One table entry as read during a scan; first marks index zero.
    typedef struct packed {
        logic       first;
        lpt_entry_t entry;
    } lpt_cand_t;

    // Write and read controls from the sequencer to the task table.
    typedef struct packed {
        logic prio_we;
        logic slice_we;
        logic rd_en;
    } lpt_tbl_ctl_t;

endpackage

`default_nettype wire

### sv/lpt_table.sv
// Task table: priority and timeslice memories with one write port and one
// registered read port. Depends on lpt_pkg.
`default_nettype none

module lpt_table
    import lpt_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int IDX_W = 4
) (
    input  wire logic                clk,
    input  wire lpt_tbl_ctl_t        ctl,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire logic [PRIO_W-1:0]   wr_prio,
    input  wire logic [SLICE_W-1:0]  wr_slice,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output logic      [PRIO_W-1:0]   rd_prio,
    output logic      [SLICE_W-1:0]  rd_slice
);

    logic [PRIO_W-1:0]  prio_mem  [DEPTH];
    logic [SLICE_W-1:0] slice_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.prio_we)
        begin
            prio_mem[wr_addr] <= wr_prio;
        end
        if (ctl.slice_we)
        begin
            slice_mem[wr_addr] <= wr_slice;
        end
        if (ctl.rd_en)
        begin
            rd_prio  <= prio_mem[rd_addr];
            rd_slice <= slice_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/lpt_min.sv
// Compare unit: keeps the running minimum entry of a table scan.
// Depends on lpt_pkg.
`default_nettype none

module lpt_min
    import lpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       cand_valid,
    input  wire lpt_cand_t  cand,
    output lpt_entry_t      best
);

    lpt_entry_t best_reg;
    lpt_entry_t best_next;

    // A strict less-than keeps the earlier index on a tie.
    always_comb
    begin
        best_next = best_reg;
        if (cand_valid && (cand.first || (cand.entry.prio < best_reg.prio)))
        begin
            best_next = cand.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

`default_nettype wire

### sv/lowest_priority_task_picker_with_aging.sv
// Lowest priority task picker with aging: top level sequencer and result register.
// Creates and misses go from idle straight to FIN; a peek or schedule on a nonempty table
// first reads every entry in SCAN, then passes through LAST and PICK before FIN.
// Throughput: one transaction at a time, set by the scan that reads one table entry per cycle.
// Reset clears the task count, the sequencer and the result valid flag; table contents stay
// undefined until written. Depends on lpt_pkg, lpt_table and lpt_min.
`default_nettype none

module lowest_priority_task_picker_with_aging
    import lpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 10
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire lpt_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output lpt_rsp_t      rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // The sequencer walks through these states for every transaction.
    // SCAN issues one table read per cycle, the compare unit consumes the read
    // data in the following cycle, LAST drains the final read, and PICK forms the answer
    // and writes back the aged priority. FIN holds the answer until the result
    // register is free.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_PICK,
        S_FIN
    } state_t;

    state_t            state_reg,    state_next;
    logic [1:0]        func_reg,     func_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_pend_reg,  rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg,   rd_idx_next;
    lpt_rsp_t          res_reg,      res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    lpt_rsp_t          rsp_reg,      rsp_next;

    lpt_tbl_ctl_t        tbl_ctl;
    logic [IDX_W-1:0]    tbl_wr_addr;
    logic [PRIO_W-1:0]   tbl_wr_prio;
    logic [PRIO_W-1:0]   tbl_rd_prio;
    logic [SLICE_W-1:0]  tbl_rd_slice;
    lpt_cand_t           cand;
    lpt_entry_t          best;

    lpt_table #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .ctl      (tbl_ctl),
        .wr_addr  (tbl_wr_addr),
        .wr_prio  (tbl_wr_prio),
        .wr_slice (req.new_timeslice),
        .rd_addr  (scan_idx_reg),
        .rd_prio  (tbl_rd_prio),
        .rd_slice (tbl_rd_slice)
    );

    // The read data that arrives this cycle belongs to the index issued last cycle.
    always_comb
    begin
        cand.first       = (rd_idx_reg == '0);
        cand.entry.prio  = tbl_rd_prio;
        cand.entry.slice = tbl_rd_slice;
        cand.entry.idx   = TASK_IDX_W'(rd_idx_reg);
    end

    lpt_min u_min (
        .clk        (clk),
        .cand_valid (rd_pend_reg),
        .cand       (cand),
        .best       (best)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        tbl_ctl        = '0;
        tbl_wr_addr    = count_reg[IDX_W-1:0];
        tbl_wr_prio    = req.new_priority;

        // The consumer takes the waiting result.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next = req.func;
                    res_next  = '0;
                    unique case (req.func) inside
                        FUNC_CREATE:
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                tbl_ctl.prio_we           = 1'b1;
                                tbl_ctl.slice_we          = 1'b1;
                                res_next.status           = ST_OK;
                                res_next.task_index       = TASK_IDX_W'(count_reg);
                                res_next.picked_priority  = req.new_priority;
                                res_next.picked_timeslice = req.new_timeslice;
                                count_next                = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                            state_next = S_FIN;
                        end
                        FUNC_PEEK, FUNC_SCHED:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                res_next.status = ST_NONE;
                                state_next      = S_FIN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_NONE;
                            state_next      = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                tbl_ctl.rd_en = 1'b1;
                rd_pend_next  = 1'b1;
                rd_idx_next   = scan_idx_reg;
                if ((CNT_W + 1)'(scan_idx_reg) + 1'b1 == (CNT_W + 1)'(count_reg))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                res_next.status           = ST_OK;
                res_next.task_index       = best.idx;
                res_next.picked_priority  = best.prio;
                res_next.picked_timeslice = best.slice;
                tbl_wr_addr               = best.idx[IDX_W-1:0];
                tbl_wr_prio               = best.prio + 1'b1;
                if ((func_reg == FUNC_SCHED) && (best.prio != PRIO_CEILING))
                begin
                    tbl_ctl.prio_we = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // The task count only ever grows by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
    else $error("task count changed by other than one");

    // The task count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
    else $error("task count beyond table size");

    // Read data is only fed to the compare unit while a scan is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ((state_reg == S_SCAN) || (state_reg == S_LAST)))
    else $error("compare unit fed outside a scan");

    // A successful result always names an entry inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_OK))
            |-> ({1'b0, rsp_reg.task_index} < (TASK_IDX_W + 1)'(MAX_ENTRIES)))
    else $error("result index outside the table");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for lowest_priority_task_picker_with_aging.
// It drives request transactions and compares every response against the directed row or its predictor.
// Depends on lpt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench
    import lpt_pkg::*;
();

    localparam int MAX_ENTRIES  = 10;
    localparam int RANDOM_ITEMS = 1528;
    // The worst case transaction is a schedule over a full table; the drain covers it with margin.
    localparam int DRAIN_CYCLES = 24;

    // The package names three function codes; the fourth one is unused and must
    // come back as "no task" without touching the table.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // One row of the directed table. When typed is set, the expected response is
    // written out in the row; otherwise the predictor supplies it.
    typedef struct {
        lpt_req_t stim;
        bit       typed;
        lpt_rsp_t want;
    } stim_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    lpt_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    lpt_rsp_t rsp;

    // Predictor copy of the task table. Entries at or above task_total are never read.
    logic [PRIO_W-1:0]  prio_tbl  [MAX_ENTRIES];
    logic [SLICE_W-1:0] slice_tbl [MAX_ENTRIES];
    int                 task_total = 0;

    lpt_rsp_t  awaited_rsp [$];
    stim_row_t directed_rows [$];

    int mismatches    = 0;
    int rsp_seen      = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    lowest_priority_task_picker_with_aging #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict the response of one accepted request and update the table the way the
    // block does: creates append, peeks only look, schedules age the pick by one and
    // stop at the ceiling. The lowest index wins a tie on priority.
    function automatic lpt_rsp_t pick_and_age(input lpt_req_t r);
        lpt_rsp_t o;
        int       best;
        int       k;
        o = '0;
        o.status = ST_NONE;
        if (r.func == FUNC_CREATE)
        begin
            if (task_total < MAX_ENTRIES)
            begin
                prio_tbl[task_total]  = r.new_priority;
                slice_tbl[task_total] = r.new_timeslice;
                o.status           = ST_OK;
                o.task_index       = task_total[TASK_IDX_W-1:0];
                o.picked_priority  = r.new_priority;
                o.picked_timeslice = r.new_timeslice;
                task_total++;
            end
            else
            begin
                o.status = ST_FULL;
            end
        end
        else if ((r.func == FUNC_PEEK || r.func == FUNC_SCHED) && task_total > 0)
        begin
            best = 0;
            for (k = 1; k < task_total; k++)
            begin
                if (prio_tbl[k] < prio_tbl[best])
                    best = k;
            end
            o.status           = ST_OK;
            o.task_index       = best[TASK_IDX_W-1:0];
            o.picked_priority  = prio_tbl[best];
            o.picked_timeslice = slice_tbl[best];
            if (r.func == FUNC_SCHED && prio_tbl[best] != PRIO_CEILING)
                prio_tbl[best] = prio_tbl[best] + 1'b1;
        end
        return o;
    endfunction

    function automatic stim_row_t make_row(
        input logic [1:0]            func,
        input logic [PRIO_W-1:0]     prio,
        input logic [SLICE_W-1:0]    slice,
        input bit                    typed,
        input logic [1:0]            status,
        input logic [TASK_IDX_W-1:0] idx,
        input logic [PRIO_W-1:0]     wprio,
        input logic [SLICE_W-1:0]    wslice
    );
        stim_row_t row;
        row.stim.func                 = func;
        row.stim.new_priority         = prio;
        row.stim.new_timeslice        = slice;
        row.typed                     = typed;
        row.want.status               = status;
        row.want.task_index           = idx;
        row.want.picked_priority      = wprio;
        row.want.picked_timeslice     = wslice;
        return row;
    endfunction

    // Every mismatch goes through here: one line printed, one count added.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_seen, msg);
    endtask

    // Present one request transaction. The sender may idle first; valid is only
    // lowered while idling, so back-to-back transactions keep it high. The expected
    // response is queued at the edge where the block accepts the transaction.
    task automatic send_request(input lpt_req_t item, input bit typed, input lpt_rsp_t want);
        lpt_rsp_t    model;
        logic [63:0] noise;
        while ($urandom_range(99) < send_idle_pct)
        begin
            noise      = {$urandom, $urandom};
            req_valid <= 1'b0;
            req       <= noise[$bits(lpt_req_t)-1:0];
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        model = pick_and_age(item);
        awaited_rsp.push_back(typed ? want : model);
    endtask

    // The receiver stalls at random with the rate of the current phase.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // Response checker: every accepted response must match the oldest expectation,
    // field by field. A response with nothing pending is a failure as well.
    always @(posedge clk)
    begin
        lpt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
            begin
                report_mismatch($sformatf("response 0x%h with nothing pending", rsp));
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              rsp.status, want.status));
                if (rsp.task_index !== want.task_index)
                    report_mismatch($sformatf("task_index got %0d, expected %0d",
                                              rsp.task_index, want.task_index));
                if (rsp.picked_priority !== want.picked_priority)
                    report_mismatch($sformatf("picked_priority got %0d, expected %0d",
                                              rsp.picked_priority, want.picked_priority));
                if (rsp.picked_timeslice !== want.picked_timeslice)
                    report_mismatch($sformatf("picked_timeslice got 0x%h, expected 0x%h",
                                              rsp.picked_timeslice, want.picked_timeslice));
            end
            rsp_seen++;
        end
    end

    // Main sequence: reset, the directed table, then four random phases with
    // different idling on the two sides, and finally the drain and the verdict.
    initial
    begin
        int       phase;
        int       n;
        int       roll;
        lpt_req_t item;
        int       phase_send  [4];
        int       phase_stall [4];

        phase_send  = '{0, 83, 0, 36};
        phase_stall = '{0, 0, 83, 36};

        // Empty table: peek and schedule have nothing to pick, and the unused code
        // answers the same way while ignoring its payload.
        directed_rows.push_back(make_row(FUNC_PEEK,   8'h00, 32'h0000_0000, 1'b1,
                                         ST_NONE, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0000_0000, 1'b1,
                                         ST_NONE, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                                         ST_NONE, 6'd0, 8'd0, 32'd0));
        // A task already at the ceiling: two schedules show that aging saturates.
        directed_rows.push_back(make_row(FUNC_CREATE, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                                         ST_OK, 6'd0, 8'hFF, 32'hFFFF_FFFF));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        // Two tasks at the lowest priority: the tie goes to the lower index until
        // aging moves it up.
        directed_rows.push_back(make_row(FUNC_CREATE, 8'h00, 32'h0000_0000, 1'b1,
                                         ST_OK, 6'd1, 8'h00, 32'h0000_0000));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'h00, 32'hA5A5_A5A5, 1'b1,
                                         ST_OK, 6'd2, 8'h00, 32'hA5A5_A5A5));
        directed_rows.push_back(make_row(FUNC_PEEK,   8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_PEEK,   8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        // Fill the rest of the table. The priorities leave enough headroom that
        // the random schedules walk the whole table up toward the ceiling.
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd100, 32'h5A5A_5A5A, 1'b1,
                                         ST_OK, 6'd3, 8'd100, 32'h5A5A_5A5A));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd254, 32'h0000_0001, 1'b1,
                                         ST_OK, 6'd4, 8'd254, 32'h0000_0001));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd200, 32'h8000_0000, 1'b1,
                                         ST_OK, 6'd5, 8'd200, 32'h8000_0000));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd150, 32'h7FFF_FFFF, 1'b1,
                                         ST_OK, 6'd6, 8'd150, 32'h7FFF_FFFF));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd250, 32'h1234_5678, 1'b1,
                                         ST_OK, 6'd7, 8'd250, 32'h1234_5678));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd180, 32'hC3C3_3C3C, 1'b1,
                                         ST_OK, 6'd8, 8'd180, 32'hC3C3_3C3C));
        directed_rows.push_back(make_row(FUNC_CREATE, 8'd128, 32'h0000_FFFF, 1'b1,
                                         ST_OK, 6'd9, 8'd128, 32'h0000_FFFF));
        // Full table: the create is refused and nothing changes.
        directed_rows.push_back(make_row(FUNC_CREATE, 8'h55, 32'hDEAD_0001, 1'b1,
                                         ST_FULL, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_UNUSED, 8'hAA, 32'h5555_AAAA, 1'b1,
                                         ST_NONE, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_PEEK,   8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));
        directed_rows.push_back(make_row(FUNC_SCHED,  8'h00, 32'h0, 1'b0,
                                         ST_OK, 6'd0, 8'd0, 32'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // Random part. The table cannot shrink, so this runs on a full table:
        // mostly schedules to drive aging and tie breaks, with peeks, refused
        // creates and the unused code mixed in. Payload bits are random every time.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_send[phase];
            rsp_stall_pct = phase_stall[phase];
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 62)
                    item.func = FUNC_SCHED;
                else if (roll < 84)
                    item.func = FUNC_PEEK;
                else if (roll < 94)
                    item.func = FUNC_CREATE;
                else
                    item.func = FUNC_UNUSED;
                item.new_priority  = PRIO_W'($urandom_range(255));
                item.new_timeslice = $urandom;
                send_request(item, 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_rsp.size() == 0)
        begin
            $display("** lowest_priority_task_picker_with_aging: PASSED **");
        end
        else
        begin
            $display("** lowest_priority_task_picker_with_aging: FAILED **");
        end
        $finish;
    end

    // Watchdog: the slowest correct run takes well under a quarter of this.
    initial
    begin
        #2_000_000;
        $display("** lowest_priority_task_picker_with_aging: FAILED **");
        $finish;
    end

endmodule

### sim.f
sv/lpt_pkg.sv
sv/lpt_table.sv
sv/lpt_min.sv
sv/lowest_priority_task_picker_with_aging.sv
bench/testbench.sv
